// ----- rtl/tkpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tkpc_pkg
// Shared types and constants for the three-key press classifier.
// ----------------------------------------------------------------------------
package tkpc_pkg;

  localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned ADDR_WIDTH = 3;
  localparam int unsigned DATA_WIDTH = 32;

  localparam logic [CFG_WIDTH-1:0] LONG_TICKS_RESET = 16'd200;
  localparam logic [CFG_WIDTH-1:0] SHORT_MIN_RESET  = 16'd2;

  // register index, taken from paddr[2]
  localparam logic REG_LONG_TICKS = 1'b0;
  localparam logic REG_SHORT_MIN  = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_MID        = 3'd1,
    EV_FRONT      = 3'd2,
    EV_REAR       = 3'd3,
    EV_MID_LONG   = 3'd4,
    EV_FRONT_LONG = 3'd5,
    EV_REAR_LONG  = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_MID      = 2'd1,
    ST_FRONT    = 2'd2,
    ST_REAR     = 2'd3
  } wheel_e;

  typedef struct packed {
    logic mid_pressed;
    logic front_pressed;
    logic rear_pressed;
  } in_req_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [1:0] wheel_state;
  } out_req_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] long_ticks;
    logic [CFG_WIDTH-1:0] short_min_ticks;
  } cfg_t;

endpackage

// ----- rtl/three_key_press_classifier.sv -----
// ----------------------------------------------------------------------------
// three_key_press_classifier
// Short/long press classifier for the middle, front and rear wheel keys.
// ----------------------------------------------------------------------------
// One request per scan tick carries the three pressed flags; every request
// gives exactly one result holding the event code and the wheel state after
// that tick. Throughput is one request per clock while the result side does
// not stall: the input register feeds the counter/compare update, which
// lands directly in the result register, and a result is valid once its
// request has passed both registers. Both sides may stall freely; a waiting
// result holds and the input register keeps the next request. Thresholds
// are set over the APB port (long_ticks at 0x0, short_min_ticks at 0x4) and
// should only be changed while no request is in flight.
module three_key_press_classifier #(
  parameter int unsigned COUNT_WIDTH = tkpc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // scan samples
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  tkpc_pkg::in_req_t                in_req_i,
  // classified results
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tkpc_pkg::out_req_t               out_req_o,
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tkpc_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [tkpc_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [tkpc_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready
);
  import tkpc_pkg::*;

  cfg_t    cfg;
  in_req_t in_q;
  logic    in_valid_q;
  logic    out_valid_q, out_valid_d;
  logic    advance;

  // Input stage moves into the core whenever the result slot is free or
  // being drained this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  tkpc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Counters, long flag and the result fields live here; the result
  // register is the core's event/state register.
  tkpc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (in_q),
    .cfg_i  (cfg),
    .res_o  (out_req_o)
  );

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while both stages are full and stalled");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("update did not produce a result");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !in_valid_q) |=> !out_valid_q)
    else $error("result repeated after it was taken");

endmodule

// ----- rtl/tkpc_apb_regs.sv -----
// ----------------------------------------------------------------------------
// tkpc_apb_regs
// APB register file holding the long and short-minimum thresholds.
// ----------------------------------------------------------------------------
module tkpc_apb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tkpc_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [tkpc_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [tkpc_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready,
  output tkpc_pkg::cfg_t                   cfg_o
);
  import tkpc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_LONG_TICKS: cfg_d.long_ticks      = pwdata[CFG_WIDTH-1:0];
        REG_SHORT_MIN:  cfg_d.short_min_ticks = pwdata[CFG_WIDTH-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ticks      <= LONG_TICKS_RESET;
      cfg_q.short_min_ticks <= SHORT_MIN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LONG_TICKS: prdata = DATA_WIDTH'(cfg_q.long_ticks);
      REG_SHORT_MIN:  prdata = DATA_WIDTH'(cfg_q.short_min_ticks);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/tkpc_core.sv -----
// ----------------------------------------------------------------------------
// tkpc_core
// Key counters, long flag and event/state registers; one update per enable.
// ----------------------------------------------------------------------------
module tkpc_core #(
  parameter int unsigned COUNT_WIDTH = tkpc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  tkpc_pkg::in_req_t  req_i,
  input  tkpc_pkg::cfg_t     cfg_i,
  output tkpc_pkg::out_req_t res_o
);
  import tkpc_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  logic [COUNT_WIDTH-1:0] mid_cnt_q, mid_cnt_d;
  logic [COUNT_WIDTH-1:0] front_cnt_q, front_cnt_d;
  logic [COUNT_WIDTH-1:0] rear_cnt_q, rear_cnt_d;
  logic                   long_fired_q, long_fired_d;
  event_e                 event_q, event_d;
  wheel_e                 held_q, held_d;

  logic [COUNT_WIDTH-1:0] held_cnt, held_inc;
  logic [CmpW-1:0]        long_ext, short_ext;
  logic                   any_pressed;
  event_e                 long_ev;

  function automatic logic is_short(logic [CmpW-1:0] c, logic [CmpW-1:0] lt,
                                    logic [CmpW-1:0] sm);
    return (c != '0) && (c < lt) && (c >= sm);
  endfunction

  assign long_ext    = CmpW'(cfg_i.long_ticks);
  assign short_ext   = CmpW'(cfg_i.short_min_ticks);
  assign any_pressed = req_i.mid_pressed || req_i.front_pressed || req_i.rear_pressed;

  // one shared incrementer for whichever key wins priority
  always_comb begin
    priority if (req_i.mid_pressed) begin
      held_cnt = mid_cnt_q;
      long_ev  = EV_MID_LONG;
    end else if (req_i.front_pressed) begin
      held_cnt = front_cnt_q;
      long_ev  = EV_FRONT_LONG;
    end else begin
      held_cnt = rear_cnt_q;
      long_ev  = EV_REAR_LONG;
    end
  end

  assign held_inc = (held_cnt == '1) ? held_cnt : held_cnt + COUNT_WIDTH'(1);

  always_comb begin
    mid_cnt_d    = mid_cnt_q;
    front_cnt_d  = front_cnt_q;
    rear_cnt_d   = rear_cnt_q;
    long_fired_d = long_fired_q;
    event_d      = event_q;
    held_d       = held_q;
    if (any_pressed) begin
      priority if (req_i.mid_pressed) begin
        mid_cnt_d = held_inc;
        held_d    = ST_MID;
      end else if (req_i.front_pressed) begin
        front_cnt_d = held_inc;
        held_d      = ST_FRONT;
      end else begin
        rear_cnt_d = held_inc;
        held_d     = ST_REAR;
      end
      if ((CmpW'(held_inc) >= long_ext) && !long_fired_q) begin
        long_fired_d = 1'b1;
        event_d      = long_ev;
      end
    end else begin
      priority if (is_short(CmpW'(mid_cnt_q), long_ext, short_ext)) begin
        event_d = EV_MID;
      end else if (is_short(CmpW'(front_cnt_q), long_ext, short_ext)) begin
        event_d = EV_FRONT;
      end else if (is_short(CmpW'(rear_cnt_q), long_ext, short_ext)) begin
        event_d = EV_REAR;
      end else begin
        event_d = EV_NONE;
      end
      mid_cnt_d    = '0;
      front_cnt_d  = '0;
      rear_cnt_d   = '0;
      long_fired_d = 1'b0;
      held_d       = ST_RELEASED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_cnt_q    <= '0;
      front_cnt_q  <= '0;
      rear_cnt_q   <= '0;
      long_fired_q <= 1'b0;
      event_q      <= EV_NONE;
      held_q       <= ST_RELEASED;
    end else if (en_i) begin
      mid_cnt_q    <= mid_cnt_d;
      front_cnt_q  <= front_cnt_d;
      rear_cnt_q   <= rear_cnt_d;
      long_fired_q <= long_fired_d;
      event_q      <= event_d;
      held_q       <= held_d;
    end
  end

  assign res_o.event_code  = event_q;
  assign res_o.wheel_state = held_q;

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == ST_RELEASED) |-> (!long_fired_q && mid_cnt_q == '0 &&
                                 front_cnt_q == '0 && rear_cnt_q == '0))
    else $error("counters or long flag not cleared while released");

  a_long_needs_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_q == EV_MID_LONG || event_q == EV_FRONT_LONG || event_q == EV_REAR_LONG)
      |-> long_fired_q)
    else $error("long event shown without long flag");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(event_q) && $stable(held_q) && $stable(mid_cnt_q)))
    else $error("state moved without an update");

endmodule

// ----- dv/tkpc_checker.sv -----
// ----------------------------------------------------------------------------
// tkpc_checker
// Watches the scan, result and APB ports of the press classifier. It keeps its
// own model of the counters and thresholds, queues the classification of each
// accepted scan request, and compares every accepted result against it.
// ----------------------------------------------------------------------------
module tkpc_checker #(
  parameter int unsigned COUNT_WIDTH = tkpc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  tkpc_pkg::in_req_t               in_req_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  tkpc_pkg::out_req_t              out_req_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [tkpc_pkg::ADDR_WIDTH-1:0] paddr_i,
  input  logic [tkpc_pkg::DATA_WIDTH-1:0] pwdata_i,
  input  logic [tkpc_pkg::DATA_WIDTH-1:0] prdata_i,
  input  logic                            pready_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tkpc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [CFG_WIDTH-1:0]   long_ticks_q;
  logic [CFG_WIDTH-1:0]   short_min_q;
  logic [COUNT_WIDTH-1:0] press_ticks [3];  // mid, front, rear
  logic                   long_seen;
  event_e                 event_q;
  wheel_e                 wheel_q;
  out_req_t               classified_q [$];

  task automatic flag(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("[%0t] checker: %s", $time, msg);
    end
  endtask

  // One scan tick: returns event and wheel state after the update.
  function automatic out_req_t classify_scan(input in_req_t keys);
    out_req_t res;
    int       k;
    k = keys.mid_pressed ? 0 : keys.front_pressed ? 1 : keys.rear_pressed ? 2 : -1;
    if (k >= 0) begin
      if (press_ticks[k] != COUNT_MAX) begin
        press_ticks[k] += 1'b1;
      end
      wheel_q = wheel_e'(ST_MID + k);
      if (press_ticks[k] >= long_ticks_q && !long_seen) begin
        long_seen = 1'b1;
        event_q   = event_e'(EV_MID_LONG + k);
      end
    end else begin
      event_q = EV_NONE;
      // walk from lowest priority up so the highest qualifying key wins
      for (int j = 2; j >= 0; j--) begin
        if (press_ticks[j] != 0 && press_ticks[j] < long_ticks_q &&
            press_ticks[j] >= short_min_q) begin
          event_q = event_e'(EV_MID + j);
        end
      end
      foreach (press_ticks[j]) press_ticks[j] = '0;
      long_seen = 1'b0;
      wheel_q   = ST_RELEASED;
    end
    res.event_code  = event_q;
    res.wheel_state = wheel_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t             want;
    logic [CFG_WIDTH-1:0] reg_val;
    if (!rst_ni) begin
      long_ticks_q = LONG_TICKS_RESET;
      short_min_q  = SHORT_MIN_RESET;
      foreach (press_ticks[j]) press_ticks[j] = '0;
      long_seen    = 1'b0;
      event_q      = EV_NONE;
      wheel_q      = ST_RELEASED;
      fail_count_o = 0;
      classified_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (classified_q.size() == 0) begin
          flag($sformatf("unexpected result event %0d wheel %0d",
                         out_req_i.event_code, out_req_i.wheel_state));
        end else begin
          want = classified_q.pop_front();
          if (out_req_i.event_code !== want.event_code ||
              out_req_i.wheel_state !== want.wheel_state) begin
            flag($sformatf("mismatch: exp event %0d wheel %0d, got event %0d wheel %0d",
                           want.event_code, want.wheel_state,
                           out_req_i.event_code, out_req_i.wheel_state));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        classified_q.push_back(classify_scan(in_req_i));
      end
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i[2])
            REG_LONG_TICKS: long_ticks_q = pwdata_i[CFG_WIDTH-1:0];
            REG_SHORT_MIN:  short_min_q  = pwdata_i[CFG_WIDTH-1:0];
            default: ;
          endcase
        end else begin
          reg_val = (paddr_i[2] == REG_LONG_TICKS) ? long_ticks_q : short_min_q;
          if (prdata_i !== DATA_WIDTH'(reg_val)) begin
            flag($sformatf("readback mismatch at 0x%0h: exp 0x%0h, got 0x%0h",
                           paddr_i, reg_val, prdata_i));
          end
        end
      end
    end
    pending_o = classified_q.size();
  end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the three-key press classifier. Drives scan
// requests under several threshold settings, with random gaps on the scan
// side and random stalls on the result side; tkpc_checker does the checking.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tkpc_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 3;
  localparam int LATENCY         = 1;       // drain margin used by settle()
  localparam int HOLD_OFF_CYCLES = 80;      // long result-side stall
  localparam int TIMEOUT_CYCLES  = 1_000_000;

  localparam logic [ADDR_WIDTH-1:0] ADDR_LONG  = {REG_LONG_TICKS, 2'b00};
  localparam logic [ADDR_WIDTH-1:0] ADDR_SHORT = {REG_SHORT_MIN, 2'b00};

  // key patterns, packed as {mid, front, rear}
  localparam in_req_t KEYS_UP  = 3'b000;
  localparam in_req_t MID      = 3'b100;
  localparam in_req_t FRONT    = 3'b010;
  localparam in_req_t REAR     = 3'b001;
  localparam in_req_t ALL_KEYS = 3'b111;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_req_t               in_req    = KEYS_UP;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_req_t              out_req;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr     = '0;
  logic [DATA_WIDTH-1:0] pwdata    = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  int   fail_count;
  int   pending;
  int   sent           = 0;
  int   send_gap_pct   = 0;
  int   recv_stall_pct = 0;
  logic hold_off_req   = 1'b0;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  three_key_press_classifier dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  tkpc_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_req_i   (out_req),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Result side: random stalls, plus one long hold-off on request so the
  // input register and result register both fill and in_ready drops.
  initial begin
    logic hold_off_done;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready     = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hard stop if the handshakes ever hang.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("simulation failed");
    $finish;
  end

  // Offer one scan request per tick for 'ticks' ticks. Entered at a falling
  // edge; returns at the falling edge after the last acceptance with valid
  // still high, so the caller either sends again or lowers valid there.
  task automatic scan(input in_req_t keys, input int ticks);
    repeat (ticks) begin
      while ($urandom_range(99) < send_gap_pct) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
      in_valid = 1'b1;
      in_req   = keys;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
      sent++;
    end
  endtask

  // Lower valid, wait for every queued classification to come out, then let
  // the pipeline latency pass so the block is truly idle.
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 1) @(negedge clk);
  endtask

  // Setup + access cycle; pready is checked at the rising edge.
  task automatic apb_xfer(input logic wr, input logic [ADDR_WIDTH-1:0] addr,
                          input logic [DATA_WIDTH-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Write both thresholds and read them back (checker compares prdata).
  task automatic set_thresholds(input int long_t, input int short_t);
    apb_xfer(1'b1, ADDR_LONG, DATA_WIDTH'(long_t));
    apb_xfer(1'b1, ADDR_SHORT, DATA_WIDTH'(short_t));
    apb_xfer(1'b0, ADDR_LONG, '0);
    apb_xfer(1'b0, ADDR_SHORT, '0);
  endtask

  // One press: a hold whose length clusters around the thresholds, maybe a
  // key change mid-hold, then a release. Some noise ticks and some presses
  // without a release are mixed in.
  task automatic press_sequence(input int long_t, input int short_t);
    int      hold;
    in_req_t keys;
    if ($urandom_range(99) < 12) begin
      scan(in_req_t'($urandom_range(7)), 1);
    end else begin
      keys = in_req_t'($urandom_range(7, 1));
      case ($urandom_range(3))
        0:       hold = short_t + int'($urandom_range(2)) - 1;
        1:       hold = long_t + int'($urandom_range(2)) - 1;
        2:       hold = $urandom_range(8, 1);
        default: hold = $urandom_range(2 * long_t + 2, 1);
      endcase
      if (hold < 1) hold = 1;
      if (hold > 300) hold = $urandom_range(64, 1);  // keep huge thresholds cheap
      scan(keys, hold);
      if ($urandom_range(99) < 30) begin
        // switch keys while still held; the long flag stays shared
        hold = (long_t < 60) ? $urandom_range(long_t + 1, 1) : $urandom_range(60, 1);
        scan(in_req_t'($urandom_range(7, 1)), hold);
      end
      if ($urandom_range(99) < 90) begin
        scan(KEYS_UP, 1);
      end
    end
  endtask

  task automatic random_phase(input int long_t, input int short_t, input int n);
    int target;
    set_thresholds(long_t, short_t);
    target = sent + n;
    while (sent < target) press_sequence(long_t, short_t);
    settle();
  endtask

  initial begin
    int long_t;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset values of both registers
    apb_xfer(1'b0, ADDR_LONG, '0);
    apb_xfer(1'b0, ADDR_SHORT, '0);

    // --- sender idles often, receiver idles more ---
    send_gap_pct   = 33;
    recv_stall_pct = 61;

    // directed presses with long = 3, short minimum = 2
    set_thresholds(3, 2);
    scan(KEYS_UP, 1);                       // release with nothing held
    scan(MID, 1);      scan(KEYS_UP, 1);    // below short minimum: none
    scan(FRONT, 2);    scan(KEYS_UP, 1);    // short front
    scan(REAR, 3);     scan(KEYS_UP, 1);    // rear long, release gives none
    scan(ALL_KEYS, 2); scan(KEYS_UP, 1);    // mid wins priority: short mid
    // mid goes long, front reaches long count but the flag is spent,
    // rear stays short and gives the short event on release
    scan(MID, 3); scan(FRONT, 3); scan(REAR, 2); scan(KEYS_UP, 1);
    settle();

    // zero thresholds: long fires on the first tick, never a short press
    set_thresholds(0, 0);
    scan(MID, 1);   scan(KEYS_UP, 1);
    scan(FRONT, 1); scan(KEYS_UP, 1);
    settle();

    hold_off_req = 1'b1;  // receiver goes quiet while we keep sending
    random_phase(10, 3, 250);
    random_phase(LONG_TICKS_RESET, SHORT_MIN_RESET, 200);

    // --- roles swapped ---
    send_gap_pct   = 61;
    recv_stall_pct = 33;
    random_phase(1, 1, 200);                // every hold is long
    random_phase(16'hFFFF, 16'hFFFF, 150);  // nothing ever qualifies

    // --- back to back, no idling ---
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    long_t = $urandom_range(40, 2);
    random_phase(long_t, $urandom_range(long_t, 1), 250);
    random_phase(12, 0, 150);

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tkpc_pkg.sv
rtl/tkpc_apb_regs.sv
rtl/tkpc_core.sv
rtl/three_key_press_classifier.sv
dv/tkpc_checker.sv
dv/tb.sv
